>>> hw/rtl/ctoa_pkg.sv
package ctoa_pkg;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KEY_RED      = 3'd0,
      CSR_KEY_GREEN    = 3'd1,
      CSR_KEY_BLUE     = 3'd2,
      CSR_CLEAR_LIMIT  = 3'd3,
      CSR_OPAQUE_LIMIT = 3'd4
   } csr_index_type;

endpackage

>>> hw/rtl/color_to_alpha_pixel.sv
// color to alpha point filter over an rgba pixel stream
// req_ channel: one pixel per transfer (red, green, blue, alpha fractions,
// all ones means 1.0). rsp_ channel: the un-blended color and the new alpha.
// csr_ port: write key color and the clear and opaque distance limits while
// no pixel is in flight; unknown indexes are dropped.
// a pixel passes three chained restoring dividers of one quotient bit
// per stage: channel alpha ratio, base color offset, division by alpha.
// throughput: one pixel per cycle while the receiver does not stall; the
// three color channels run in their own lanes and a merge stage picks
// the strongest channel alpha.
// the whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline freezes and req_stall rises until the result
// is taken. a result register empty or draining lets a new pixel in.
// reset empties the pipeline and loads the key to white, clear limit 0 and
// opaque limit full scale.
module color_to_alpha_pixel #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [CHANNEL_BITS-1:0]          req_in_red,
   input  logic [CHANNEL_BITS-1:0]          req_in_green,
   input  logic [CHANNEL_BITS-1:0]          req_in_blue,
   input  logic [CHANNEL_BITS-1:0]          req_in_alpha,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [CHANNEL_BITS-1:0]          rsp_out_red,
   output logic [CHANNEL_BITS-1:0]          rsp_out_green,
   output logic [CHANNEL_BITS-1:0]          rsp_out_blue,
   output logic [CHANNEL_BITS-1:0]          rsp_out_alpha,
   input  logic                             csr_write_enable,
   input  logic [ctoa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CHANNEL_BITS-1:0]          csr_data
);

   localparam int W = CHANNEL_BITS;
   localparam logic [W-1:0] FULL = '1;

   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // configuration registers
   logic [W-1:0] key_ff [3];
   logic [W-1:0] clear_ff;
   logic [W-1:0] opaque_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= FULL;
         key_ff[1] <= FULL;
         key_ff[2] <= FULL;
         clear_ff  <= '0;
         opaque_ff <= FULL;
      end else if (csr_write_enable) begin
         case (csr_index)
            ctoa_pkg::CSR_KEY_RED:      key_ff[0] <= csr_data;
            ctoa_pkg::CSR_KEY_GREEN:    key_ff[1] <= csr_data;
            ctoa_pkg::CSR_KEY_BLUE:     key_ff[2] <= csr_data;
            ctoa_pkg::CSR_CLEAR_LIMIT:  clear_ff  <= csr_data;
            ctoa_pkg::CSR_OPAQUE_LIMIT: opaque_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   logic         in_valid_ff;
   logic [W-1:0] in_pix_ff [3];
   logic [W-1:0] in_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_pix_ff[0] <= req_in_red;
         in_pix_ff[1] <= req_in_green;
         in_pix_ff[2] <= req_in_blue;
         in_alpha_ff  <= req_in_alpha;
      end
   end

   // per channel alpha lanes
   logic         a_valid [3];
   logic [W-1:0] a_alpha [3];
   logic [W-1:0] a_dist  [3];
   logic [W-1:0] a_pix   [3];
   logic [W-1:0] a_ia;

   ctoa_alpha_lane #(.W(W), .TW(W)) u_alpha_red (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(in_valid_ff),
      .pix_in(in_pix_ff[0]), .key(key_ff[0]), .clear_limit(clear_ff),
      .opaque_limit(opaque_ff), .tag_in(in_alpha_ff),
      .out_valid(a_valid[0]), .alpha(a_alpha[0]), .distance(a_dist[0]),
      .pix_out(a_pix[0]), .tag_out(a_ia)
   );

   ctoa_alpha_lane #(.W(W), .TW(1)) u_alpha_green (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(in_valid_ff),
      .pix_in(in_pix_ff[1]), .key(key_ff[1]), .clear_limit(clear_ff),
      .opaque_limit(opaque_ff), .tag_in(1'b0),
      .out_valid(a_valid[1]), .alpha(a_alpha[1]), .distance(a_dist[1]),
      .pix_out(a_pix[1]), .tag_out()
   );

   ctoa_alpha_lane #(.W(W), .TW(1)) u_alpha_blue (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(in_valid_ff),
      .pix_in(in_pix_ff[2]), .key(key_ff[2]), .clear_limit(clear_ff),
      .opaque_limit(opaque_ff), .tag_in(1'b0),
      .out_valid(a_valid[2]), .alpha(a_alpha[2]), .distance(a_dist[2]),
      .pix_out(a_pix[2]), .tag_out()
   );

   // merge: first strictly largest channel alpha wins
   logic [W-1:0] best_in;
   logic [W-1:0] dist_in;

   always_comb begin
      best_in = '0;
      dist_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (a_alpha[i] > best_in) begin
            best_in = a_alpha[i];
            dist_in = a_dist[i];
         end
      end
   end

   logic         m_valid_ff;
   logic [W-1:0] m_pix_ff [3];
   logic [W-1:0] m_best_ff;
   logic [W-1:0] m_dist_ff;
   logic         m_active_ff;
   logic [W-1:0] m_ia_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= a_valid[0] && a_valid[1] && a_valid[2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_pix_ff[0] <= a_pix[0];
         m_pix_ff[1] <= a_pix[1];
         m_pix_ff[2] <= a_pix[2];
         m_best_ff   <= best_in;
         m_dist_ff   <= dist_in;
         m_active_ff <= (best_in > {{(W-1){1'b0}}, 1'b1}) && (dist_in != '0);
         m_ia_ff     <= a_ia;
      end
   end

   // un-blend lanes; the red lane carries the alpha product along
   logic [2*W-1:0] alpha_prod;
   logic [2*W-1:0] u_prod;
   logic           u_valid [3];
   logic [W-1:0]   u_res   [3];

   assign alpha_prod = m_ia_ff * m_best_ff;

   ctoa_unblend_lane #(.W(W), .TW(2*W)) u_unblend_red (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(m_valid_ff),
      .pix_in(m_pix_ff[0]), .key(key_ff[0]), .clear_limit(clear_ff),
      .distance(m_dist_ff), .alpha(m_best_ff), .active(m_active_ff),
      .tag_in(alpha_prod), .out_valid(u_valid[0]), .res(u_res[0]), .tag_out(u_prod)
   );

   ctoa_unblend_lane #(.W(W), .TW(1)) u_unblend_green (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(m_valid_ff),
      .pix_in(m_pix_ff[1]), .key(key_ff[1]), .clear_limit(clear_ff),
      .distance(m_dist_ff), .alpha(m_best_ff), .active(m_active_ff),
      .tag_in(1'b0), .out_valid(u_valid[1]), .res(u_res[1]), .tag_out()
   );

   ctoa_unblend_lane #(.W(W), .TW(1)) u_unblend_blue (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(m_valid_ff),
      .pix_in(m_pix_ff[2]), .key(key_ff[2]), .clear_limit(clear_ff),
      .distance(m_dist_ff), .alpha(m_best_ff), .active(m_active_ff),
      .tag_in(1'b0), .out_valid(u_valid[2]), .res(u_res[2]), .tag_out()
   );

   // rounded divide by full scale: n/(2^W-1) = (n + (n >> W) + 1) >> W
   logic [2*W:0]  n_round;
   logic [2*W:0]  n_sum;
   logic [W-1:0]  out_alpha_in;

   assign n_round      = {1'b0, u_prod} + {{(W+1){1'b0}}, 1'b0, FULL[W-1:1]};
   assign n_sum        = n_round + (n_round >> W) + {{(2*W){1'b0}}, 1'b1};
   assign out_alpha_in = n_sum[2*W-1:W];

   // result register
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_red_ff;
   logic [W-1:0] rsp_green_ff;
   logic [W-1:0] rsp_blue_ff;
   logic [W-1:0] rsp_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= u_valid[0] && u_valid[1] && u_valid[2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_red_ff   <= u_res[0];
         rsp_green_ff <= u_res[1];
         rsp_blue_ff  <= u_res[2];
         rsp_alpha_ff <= out_alpha_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

endmodule

>>> hw/rtl/ctoa_div.sv
// restoring divider, one quotient bit per stage
// in_hi must be below in_den for the quotient to fit in QW bits
module ctoa_div #(
   parameter int DW = 16,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_hi,
   input  logic [QW-1:0] in_lo,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [QW];
   logic [DW-1:0] rem_ff   [QW];
   logic [QW-1:0] quo_ff   [QW];
   logic [DW-1:0] den_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   genvar i;
   for (i = 0; i < QW; i++) begin : g_stage
      logic          v_src;
      logic [DW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_hi;
         assign quo_src  = in_lo;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign quo_src  = quo_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      assign trial  = {rem_src, quo_src[QW-1]};
      assign diff   = trial - {1'b0, den_src};
      assign rem_in = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      assign quo_in = {quo_src[QW-2:0], ~diff[DW]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            quo_ff[i]  <= quo_in;
            den_ff[i]  <= den_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> hw/rtl/ctoa_alpha_lane.sv
module ctoa_alpha_lane #(
   parameter int W  = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [W-1:0]  pix_in,
   input  logic [W-1:0]  key,
   input  logic [W-1:0]  clear_limit,
   input  logic [W-1:0]  opaque_limit,
   input  logic [TW-1:0] tag_in,
   output logic          out_valid,
   output logic [W-1:0]  alpha,
   output logic [W-1:0]  distance,
   output logic [W-1:0]  pix_out,
   output logic [TW-1:0] tag_out
);

   localparam logic [W-1:0] FULL = '1;
   localparam int SW = 2 + 2*W + TW;

   logic [W-1:0]   d;
   logic           clr;
   logic           opq;
   logic [W-1:0]   lim;
   logic [W-1:0]   den;
   logic [W-1:0]   dt;
   logic [2*W-1:0] dt_ext;
   logic [2*W-1:0] num;
   logic [SW-1:0]  side_in;
   logic [SW-1:0]  side_out;
   logic [W-1:0]   quo;
   logic           clr_q;
   logic           opq_q;

   always_comb begin
      d   = (pix_in >= key) ? pix_in - key : key - pix_in;
      clr = d <= clear_limit;
      opq = d >= opaque_limit;
      if (pix_in < key) begin
         lim = (opaque_limit < key) ? opaque_limit : key;
      end else begin
         lim = (opaque_limit < FULL - key) ? opaque_limit : FULL - key;
      end
      den    = lim - clear_limit;
      dt     = d - clear_limit;
      dt_ext = {{W{1'b0}}, dt};
      // times full scale is a shift and a subtract
      num    = (dt_ext << W) - dt_ext + {{W{1'b0}}, 1'b0, den[W-1:1]};
   end

   assign side_in = {clr, opq, d, pix_in, tag_in};

   ctoa_div #(.DW(W), .QW(W), .SW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (in_valid),
      .in_hi    (num[2*W-1:W]),
      .in_lo    (num[W-1:0]),
      .in_den   (den),
      .in_side  (side_in),
      .out_valid(out_valid),
      .out_quo  (quo),
      .out_side (side_out)
   );

   assign {clr_q, opq_q, distance, pix_out, tag_out} = side_out;
   assign alpha = clr_q ? '0 : (opq_q ? FULL : quo);

endmodule

>>> hw/rtl/ctoa_unblend_lane.sv
module ctoa_unblend_lane #(
   parameter int W  = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [W-1:0]  pix_in,
   input  logic [W-1:0]  key,
   input  logic [W-1:0]  clear_limit,
   input  logic [W-1:0]  distance,
   input  logic [W-1:0]  alpha,
   input  logic          active,
   input  logic [TW-1:0] tag_in,
   output logic          out_valid,
   output logic [W-1:0]  res,
   output logic [TW-1:0] tag_out
);

   localparam logic [W-1:0] FULL = '1;
   localparam int SW1 = 2*W + 2 + TW;
   localparam int SW2 = 2*W + 3 + TW;

   // stage 0: offset from key times clear limit
   logic [W-1:0]   mag;
   logic           valid0_ff;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [W-1:0]   pix0_ff;
   logic           ge0_ff;
   logic [W-1:0]   dist0_ff;
   logic [W-1:0]   alpha0_ff;
   logic           active0_ff;
   logic [TW-1:0]  tag0_ff;

   assign mag     = (pix_in >= key) ? pix_in - key : key - pix_in;
   assign prod_in = mag * clear_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (enable) begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff    <= prod_in;
         pix0_ff    <= pix_in;
         ge0_ff     <= pix_in >= key;
         dist0_ff   <= distance;
         alpha0_ff  <= alpha;
         active0_ff <= active;
         tag0_ff    <= tag_in;
      end
   end

   // rounded scale of the offset by clear limit over distance
   logic [2*W-1:0] num1;
   logic [SW1-1:0] side1_in, side1_out;
   logic           valid1;
   logic [W-1:0]   q1;
   logic [W-1:0]   pix1;
   logic           ge1;
   logic [W-1:0]   alpha1;
   logic           active1;
   logic [TW-1:0]  tag1;

   assign num1     = prod_ff + {{W{1'b0}}, 1'b0, dist0_ff[W-1:1]};
   assign side1_in = {pix0_ff, ge0_ff, alpha0_ff, active0_ff, tag0_ff};

   ctoa_div #(.DW(W), .QW(W), .SW(SW1)) u_div_mix (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (valid0_ff),
      .in_hi    (num1[2*W-1:W]),
      .in_lo    (num1[W-1:0]),
      .in_den   (dist0_ff),
      .in_side  (side1_in),
      .out_valid(valid1),
      .out_quo  (q1),
      .out_side (side1_out)
   );

   assign {pix1, ge1, alpha1, active1, tag1} = side1_out;

   // stage 1: base color and distance to it
   logic [W-1:0]  base_in;
   logic          valid2_ff;
   logic [W-1:0]  base_ff;
   logic          xge_ff;
   logic [W-1:0]  span_ff;
   logic [W-1:0]  pix2_ff;
   logic [W-1:0]  alpha2_ff;
   logic          active2_ff;
   logic [TW-1:0] tag2_ff;

   assign base_in = ge1 ? key + q1 : key - q1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid2_ff <= valid1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         base_ff    <= base_in;
         xge_ff     <= pix1 >= base_in;
         span_ff    <= (pix1 >= base_in) ? pix1 - base_in : base_in - pix1;
         pix2_ff    <= pix1;
         alpha2_ff  <= alpha1;
         active2_ff <= active1;
         tag2_ff    <= tag1;
      end
   end

   // divide by alpha, overflow past full scale caught up front
   logic [2*W-1:0] span_ext;
   logic [2*W-1:0] num2;
   logic           sat_in;
   logic [SW2-1:0] side2_in, side2_out;
   logic [W-1:0]   q2;
   logic [W-1:0]   base3;
   logic           xge3;
   logic           sat3;
   logic [W-1:0]   pix3;
   logic           active3;

   assign span_ext = {{W{1'b0}}, span_ff};
   assign num2     = (span_ext << W) - span_ext + {{W{1'b0}}, 1'b0, alpha2_ff[W-1:1]};
   assign sat_in   = num2[2*W-1:W] >= alpha2_ff;
   assign side2_in = {base_ff, xge_ff, sat_in, pix2_ff, active2_ff, tag2_ff};

   ctoa_div #(.DW(W), .QW(W), .SW(SW2)) u_div_alpha (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (valid2_ff),
      .in_hi    (num2[2*W-1:W]),
      .in_lo    (num2[W-1:0]),
      .in_den   (alpha2_ff),
      .in_side  (side2_in),
      .out_valid(out_valid),
      .out_quo  (q2),
      .out_side (side2_out)
   );

   assign {base3, xge3, sat3, pix3, active3, tag_out} = side2_out;

   always_comb begin
      if (!active3) begin
         res = pix3;
      end else if (xge3) begin
         res = (sat3 || q2 > FULL - base3) ? FULL : base3 + q2;
      end else begin
         res = (sat3 || q2 > base3) ? '0 : base3 - q2;
      end
   end

endmodule
